@@ sv/swhc_pkg.sv @@
// shared types and constants for the sliding window hit counter
package swhc_pkg;

   localparam int WINDOW_BUCKETS_DEF = 900;
   localparam int TIME_W             = 32;
   localparam int BUCKET_W           = 16;
   localparam int TOTAL_W            = 26;

   localparam logic [BUCKET_W-1:0] BUCKET_MAX = {BUCKET_W{1'b1}};
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};

   // command field codes
   localparam logic CMD_HIT   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CAP,
      ST_ADV,
      ST_FETCH,
      ST_UPDATE,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture the request and work out the time gap
      logic cap;     // limit the gap to the ring length
      logic step;    // advance the ring by one bucket and clear it
      logic clr;     // one step of the clearing pass
      logic fetch;   // read the current bucket
      logic update;  // apply a hit to bucket and total
      logic emit;    // load the result register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic steps_zero;
      logic clr_last;
   } dp_sts_type;

endpackage

@@ sv/swhc_datapath.sv @@
// bucket ring memory, pointers, running total and result register
module swhc_datapath #(
   parameter int WINDOW_BUCKETS = swhc_pkg::WINDOW_BUCKETS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swhc_pkg::dp_cmd_type          cmd,
   output swhc_pkg::dp_sts_type          sts,
   input  logic                          req_command,
   input  logic [swhc_pkg::TIME_W-1:0]   req_now_seconds,
   output logic [swhc_pkg::TOTAL_W-1:0]  rsp_window_count
);
   import swhc_pkg::*;

   localparam int IW = $clog2(WINDOW_BUCKETS);
   localparam int SW = $clog2(WINDOW_BUCKETS + 1);
   localparam logic [IW-1:0]     LAST_IDX = IW'(WINDOW_BUCKETS - 1);
   localparam logic [SW-1:0]     RING_LEN = SW'(WINDOW_BUCKETS);
   localparam logic [TIME_W-1:0] RING_LEN_T = TIME_W'(WINDOW_BUCKETS);

   logic [BUCKET_W-1:0] bucket_mem [WINDOW_BUCKETS];

   logic [IW-1:0]       cur_ff, cur_in, cur_next;
   logic [TIME_W-1:0]   last_ff, last_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [SW-1:0]       steps_ff, steps_in;
   logic [TIME_W-1:0]   diff_ff, diff_in;
   logic                fwd_ff, fwd_in;
   logic                cmd_ff, cmd_in;
   logic                sub_pending_ff, sub_pending_in;
   logic [BUCKET_W-1:0] rd_data_ff;
   logic [TOTAL_W-1:0]  out_ff, out_in;

   logic [TIME_W:0]     gap_full;
   logic                hit_ok;
   logic                mem_we, mem_re;
   logic [IW-1:0]       mem_addr;
   logic [BUCKET_W-1:0] mem_wdata;

   assign cur_next = (cur_ff == LAST_IDX) ? '0 : cur_ff + 1'b1;
   assign gap_full = {1'b0, req_now_seconds} - {1'b0, last_ff};
   assign hit_ok   = (cmd_ff == CMD_HIT) && (rd_data_ff != BUCKET_MAX)
                     && (total_ff != TOTAL_MAX);

   always_comb begin
      cur_in         = cur_ff;
      last_in        = last_ff;
      diff_in        = diff_ff;
      fwd_in         = fwd_ff;
      cmd_in         = cmd_ff;
      steps_in       = steps_ff;
      sub_pending_in = 1'b0;
      out_in         = out_ff;
      total_in       = total_ff;

      if (cmd.load) begin
         diff_in = gap_full[TIME_W-1:0];
         fwd_in  = ~gap_full[TIME_W];
         cmd_in  = req_command;
         last_in = req_now_seconds;
      end
      if (cmd.cap) begin
         if (!fwd_ff) begin
            steps_in = '0;
         end else if (diff_ff > RING_LEN_T) begin
            steps_in = RING_LEN;
         end else begin
            steps_in = diff_ff[SW-1:0];
         end
      end
      if (cmd.step) begin
         cur_in         = cur_next;
         steps_in       = steps_ff - 1'b1;
         sub_pending_in = 1'b1;
      end
      if (cmd.clr) begin
         cur_in = cur_next;
      end

      // add an accepted hit on update, else subtract the bucket read in the previous advance step
      if (cmd.update) begin
         if (hit_ok) begin
            total_in = total_ff + 1'b1;
         end
      end else if (sub_pending_ff) begin
         if (total_ff >= TOTAL_W'(rd_data_ff)) begin
            total_in = total_ff - TOTAL_W'(rd_data_ff);
         end else begin
            total_in = '0;
         end
      end

      if (cmd.emit) begin
         out_in = total_ff;
      end
   end

   // single port, read-before-write
   assign mem_addr  = cmd.step ? cur_next : cur_ff;
   assign mem_re    = cmd.step | cmd.fetch;
   assign mem_we    = cmd.step | cmd.clr | (cmd.update & hit_ok);
   assign mem_wdata = cmd.update ? rd_data_ff + 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= bucket_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff         <= '0;
         last_ff        <= '0;
         total_ff       <= '0;
         steps_ff       <= '0;
         sub_pending_ff <= 1'b0;
      end else begin
         cur_ff         <= cur_in;
         last_ff        <= last_in;
         total_ff       <= total_in;
         steps_ff       <= steps_in;
         sub_pending_ff <= sub_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      fwd_ff  <= fwd_in;
      cmd_ff  <= cmd_in;
      out_ff  <= out_in;
   end

   assign sts.steps_zero   = (steps_ff == '0);
   assign sts.clr_last     = (cur_ff == LAST_IDX);
   assign rsp_window_count = out_ff;

endmodule

@@ sv/swhc_ctrl.sv @@
// sequencing state machine and handshake control
module swhc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  swhc_pkg::dp_sts_type  sts,
   output swhc_pkg::dp_cmd_type  cmd,
   output swhc_pkg::state_type   state
);
   import swhc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_CAP;
         ST_CAP:    state_in = ST_ADV;
         ST_ADV:    if (sts.steps_zero) state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_RESP;
         ST_RESP:   if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clr = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CAP:    cmd.cap = 1'b1;
         ST_ADV:    cmd.step = ~sts.steps_zero;
         ST_FETCH:  cmd.fetch = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         ST_RESP:   cmd.emit = slot_free;
         default:   cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign state     = state_ff;

endmodule

@@ sv/sliding_window_hit_counter.sv @@
// top level of the sliding window hit counter
// Counts hits over a sliding window of WINDOW_BUCKETS one-second buckets kept in a
// ring in a single-port memory. Each request transfer carries a command (hit or
// query) and the current time in seconds; each one gives exactly one response
// transfer with the window total after that item. The ring is advanced by the
// seconds elapsed since the previous item, capped at the ring length, clearing
// one bucket per cycle through the memory port. After a request transfer the
// controller steps through the capping, advance, fetch, update and result states;
// the response becomes valid in the same cycle in which req_ready rises again.
// Items are handled one at a time; a finished result waits in an output register
// while the next request is taken. After reset a clearing pass writes every
// bucket to zero, one per cycle, before req_ready first rises.
module sliding_window_hit_counter #(
   parameter int WINDOW_BUCKETS = swhc_pkg::WINDOW_BUCKETS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [swhc_pkg::TIME_W-1:0]   req_now_seconds,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swhc_pkg::TOTAL_W-1:0]  rsp_window_count
);
   import swhc_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   state_type  state;

   // sequencer: clearing pass, gap capping, ring advance, hit update, result
   swhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd),
      .state     (state)
   );

   // bucket memory, ring pointer, last time, running total
   swhc_datapath #(
      .WINDOW_BUCKETS (WINDOW_BUCKETS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_command      (req_command),
      .req_now_seconds  (req_now_seconds),
      .rsp_window_count (rsp_window_count)
   );

   // a request transfer starts a busy period
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready still high after a request transfer");

   // a response only appears out of the result state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state == ST_RESP))
      else $error("response raised outside the result state");

   // the ring never steps past the capped gap
   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !sts.steps_zero)
      else $error("ring advanced with no steps left");

   // nothing is accepted during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> (!req_ready && !cmd.load))
      else $error("request taken during the clearing pass");

endmodule
